@@ rtl/core/cbtp_pkg.sv @@
// Package for the colour-bar test pattern pixel block: colour codes and
// geometry constants. No dependencies.
package cbtp_pkg;

    // Colour selector; the value is also the configuration register index.
    typedef enum logic [2:0] {
        CLR_BLACK   = 3'd0,
        CLR_WHITE   = 3'd1,
        CLR_YELLOW  = 3'd2,
        CLR_CYAN    = 3'd3,
        CLR_GREEN   = 3'd4,
        CLR_MAGENTA = 3'd5,
        CLR_RED     = 3'd6,
        CLR_BLUE    = 3'd7
    } colour_t;

    localparam int NUM_CODES = 8;
    localparam int CODE_W    = 8;
    localparam int CFG_IDX_W = 8;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int FRAME_W = 32;

    // Frame counter is reduced one hex digit per pipeline stage.
    localparam int DIGIT_W   = 4;
    localparam int NUM_DIGIT = FRAME_W / DIGIT_W;

    localparam int SYNC_BLOCK = 20;

    localparam int ROW_DEN     = 240;
    localparam int TOP_NUM     = 160;
    localparam int MID_NUM     = 180;
    localparam int SYNC_LO_NUM = 225;
    localparam int SYNC_HI_NUM = 235;

    localparam int BAR_COUNT = 7;
    localparam int LAST_BAR  = 6;

    localparam int THRESH_SCALE = 32;
    localparam int THRESH_LEVEL = 16;

endpackage

@@ rtl/core/colour_bar_test_pattern_pixel.sv @@
// Top level of the colour-bar test pattern pixel generator: geometry decode,
// pipelined frame-position reduction and palette code registers. Uses cbtp_pkg.
//
// One beat in gives one palette index out, in order. The block takes one beat
// per clock and delivers one per clock while pixel_stall stays low; an
// accepted coordinate beat passes through the eight-stage digit-serial
// reduction of frame_number modulo (LINE_PIXELS - 20) that places the moving
// white sync block, then through the output register that maps the colour
// to its code. The band (top bars, mid bars, bottom section) is decoded from
// row and column in the first stage by constant compares only.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles collapse and new beats enter while a finished
// pixel waits on pixel_stall; coord_stall rises only when every stage is full.
// Colour codes live in eight 8-bit registers written through the cfg port
// (cfg_ready is always high; indexes beyond the list are dropped); write them
// only while no beat is in flight.
module colour_bar_test_pattern_pixel #(
    parameter int LINE_PIXELS = 640,
    parameter int FRAME_LINES = 480
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           coord_valid,
    output logic                           coord_stall,
    input  logic [cbtp_pkg::COL_W-1:0]     column,
    input  logic [cbtp_pkg::ROW_W-1:0]     row,
    input  logic [cbtp_pkg::FRAME_W-1:0]   frame_number,

    output logic                           pixel_valid,
    input  logic                           pixel_stall,
    output logic [cbtp_pkg::CODE_W-1:0]    pixel_color,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cbtp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbtp_pkg::CODE_W-1:0]    cfg_data
);

    // Geometry, all elaboration-time constants.
    localparam int SYNC_MOD = LINE_PIXELS - cbtp_pkg::SYNC_BLOCK;
    localparam int RW       = $clog2(SYNC_MOD);
    localparam int TW       = RW + cbtp_pkg::DIGIT_W;
    localparam int NS       = cbtp_pkg::NUM_DIGIT;

    localparam int BAR_PIX  = LINE_PIXELS / cbtp_pkg::BAR_COUNT;
    localparam int SPLIT    = LINE_PIXELS * 3 / 4;
    localparam int THR      = (cbtp_pkg::THRESH_LEVEL + 1) * SPLIT;
    localparam int SEG_PIX  = (LINE_PIXELS / 4) / 3;

    localparam int ROW_TOP  = FRAME_LINES * cbtp_pkg::TOP_NUM / cbtp_pkg::ROW_DEN;
    localparam int ROW_MID  = FRAME_LINES * cbtp_pkg::MID_NUM / cbtp_pkg::ROW_DEN;
    localparam int ROW_SY0  = FRAME_LINES * cbtp_pkg::SYNC_LO_NUM / cbtp_pkg::ROW_DEN;
    localparam int ROW_SY1  = FRAME_LINES * cbtp_pkg::SYNC_HI_NUM / cbtp_pkg::ROW_DEN;

    // One remainder step: shift in a digit, then reduce below SYNC_MOD with
    // restoring compare-subtract against SYNC_MOD scaled by 8, 4, 2, 1.
    function automatic logic [RW-1:0] rem_step(input logic [RW-1:0] r,
                                               input logic [cbtp_pkg::DIGIT_W-1:0] d);
        logic [TW-1:0] t;
        t = {r, d};
        for (int k = cbtp_pkg::DIGIT_W - 1; k >= 0; k--) begin
            if (t >= (TW'(SYNC_MOD) << k))
            begin
                t = t - (TW'(SYNC_MOD) << k);
            end
        end
        return t[RW-1:0];
    endfunction

    // Pipeline storage: stages 0..NS-1 reduce the frame, stage NS is the output.
    logic [NS:0]                   valid_reg;
    logic [NS:0]                   valid_next;
    logic [NS:0]                   ready;
    logic [cbtp_pkg::COL_W-1:0]    col_reg    [0:NS-1];
    logic [cbtp_pkg::FRAME_W-1:0]  frame_reg  [0:NS-1];
    logic [RW-1:0]                 rem_reg    [0:NS-1];
    logic [RW-1:0]                 rem_next   [0:NS-1];
    cbtp_pkg::colour_t             colour_reg [0:NS-1];
    logic [NS-1:0]                 sync_reg;
    logic [cbtp_pkg::CODE_W-1:0]   pixel_color_reg;
    logic [cbtp_pkg::CODE_W-1:0]   pixel_color_next;
    logic [cbtp_pkg::CODE_W-1:0]   code_reg   [0:cbtp_pkg::NUM_CODES-1];

    cbtp_pkg::colour_t             base_colour;
    logic                          base_sync;
    logic [2:0]                    bar;
    cbtp_pkg::colour_t             final_colour;
    logic                          sync_hit;

    // Backpressure: a stage may load when empty or when its successor moves.
    assign ready[NS] = !valid_reg[NS] || !pixel_stall;
    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_ready
            assign ready[g] = !valid_reg[g] || ready[g+1];
        end
    endgenerate

    assign coord_stall = !ready[0];
    assign pixel_valid = valid_reg[NS];
    assign pixel_color = pixel_color_reg;
    assign cfg_ready   = 1'b1;

    // Band decode from the incoming coordinate.
    always_comb
    begin
        bar = 3'd0;
        for (int k = 1; k <= cbtp_pkg::LAST_BAR; k++) begin
            if (32'(column) >= k * BAR_PIX)
            begin
                bar = 3'(k);
            end
        end

        if (32'(row) < ROW_TOP)
        begin
            case (bar)
                3'd0:    base_colour = cbtp_pkg::CLR_WHITE;
                3'd1:    base_colour = cbtp_pkg::CLR_YELLOW;
                3'd2:    base_colour = cbtp_pkg::CLR_CYAN;
                3'd3:    base_colour = cbtp_pkg::CLR_GREEN;
                3'd4:    base_colour = cbtp_pkg::CLR_MAGENTA;
                3'd5:    base_colour = cbtp_pkg::CLR_RED;
                default: base_colour = cbtp_pkg::CLR_BLUE;
            endcase
        end
        else if (32'(row) < ROW_MID)
        begin
            case (bar)
                3'd0:    base_colour = cbtp_pkg::CLR_BLUE;
                3'd2:    base_colour = cbtp_pkg::CLR_MAGENTA;
                3'd4:    base_colour = cbtp_pkg::CLR_CYAN;
                3'd6:    base_colour = cbtp_pkg::CLR_WHITE;
                default: base_colour = cbtp_pkg::CLR_BLACK;
            endcase
        end
        else if (32'(column) < SPLIT)
        begin
            // Threshold region: white once column*32/split passes 16.
            base_colour = (32'(column) * cbtp_pkg::THRESH_SCALE >= THR) ?
                          cbtp_pkg::CLR_WHITE : cbtp_pkg::CLR_BLACK;
        end
        else if (32'(column) < SPLIT + SEG_PIX)
        begin
            base_colour = cbtp_pkg::CLR_BLACK;
        end
        else if (32'(column) < SPLIT + 2 * SEG_PIX)
        begin
            base_colour = cbtp_pkg::CLR_BLUE;
        end
        else
        begin
            base_colour = cbtp_pkg::CLR_WHITE;
        end

        // The sync band always lies inside the bottom section.
        base_sync = (32'(row) >= ROW_SY0) && (32'(row) < ROW_SY1);
    end

    // Reduction stages, most significant digit first.
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            localparam int HI = cbtp_pkg::FRAME_W - 1 - cbtp_pkg::DIGIT_W * g;
            if (g == 0) begin : g_first
                always_comb
                begin
                    valid_next[g] = coord_valid;
                    rem_next[g]   = rem_step(RW'(0), frame_number[HI -: cbtp_pkg::DIGIT_W]);
                end

                always_ff @(posedge clk)
                begin
                    if (ready[g] && coord_valid)
                    begin
                        col_reg[g]    <= column;
                        frame_reg[g]  <= frame_number;
                        rem_reg[g]    <= rem_next[g];
                        colour_reg[g] <= base_colour;
                        sync_reg[g]   <= base_sync;
                    end
                end
            end
            else begin : g_rest
                always_comb
                begin
                    valid_next[g] = valid_reg[g-1];
                    rem_next[g]   = rem_step(rem_reg[g-1],
                                             frame_reg[g-1][HI -: cbtp_pkg::DIGIT_W]);
                end

                always_ff @(posedge clk)
                begin
                    if (ready[g] && valid_reg[g-1])
                    begin
                        col_reg[g]    <= col_reg[g-1];
                        frame_reg[g]  <= frame_reg[g-1];
                        rem_reg[g]    <= rem_next[g];
                        colour_reg[g] <= colour_reg[g-1];
                        sync_reg[g]   <= sync_reg[g-1];
                    end
                end
            end
        end
    endgenerate

    // Output stage: overlay the sync block, then look up the palette code.
    always_comb
    begin
        valid_next[NS] = valid_reg[NS-1];
        sync_hit = (32'(col_reg[NS-1]) >= 32'(rem_reg[NS-1])) &&
                   (32'(col_reg[NS-1]) < 32'(rem_reg[NS-1]) + cbtp_pkg::SYNC_BLOCK);
        final_colour = (sync_reg[NS-1] && sync_hit) ? cbtp_pkg::CLR_WHITE
                                                   : colour_reg[NS-1];
        pixel_color_next = code_reg[final_colour];
    end

    always_ff @(posedge clk)
    begin
        if (ready[NS] && valid_reg[NS-1])
        begin
            pixel_color_reg <= pixel_color_next;
        end
    end

    // Valid bits advance wherever the stage is free to load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i <= NS; i++) begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    // Palette code registers; reset value of each equals its index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cbtp_pkg::NUM_CODES; i++) begin
                code_reg[i] <= cbtp_pkg::CODE_W'(i);
            end
        end
        else if (cfg_valid && cfg_ready && (32'(cfg_index) < cbtp_pkg::NUM_CODES))
        begin
            code_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Input is held off only when every stage holds a beat.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        coord_stall |-> ($countones(valid_reg) == NS + 1))
        else $error("coord_stall with an empty pipeline stage");

    // Frame position must be fully reduced before the sync compare.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NS-1] |-> (32'(rem_reg[NS-1]) < SYNC_MOD))
        else $error("frame position not reduced below line width minus block");

    // A beat in the last reduction stage reaches the output when it is free.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NS-1] && (!valid_reg[NS] || !pixel_stall)) |=> pixel_valid)
        else $error("pixel beat lost between last stage and output");

endmodule

@@ test/colour_bar_test_pattern_pixel_tb.sv @@
// Self-checking bench for colour_bar_test_pattern_pixel: drives coordinate beats,
// predicts each palette index and checks the pixel stream in order.
// Depends on cbtp_pkg and the RTL of the block under test.
module colour_bar_test_pattern_pixel_tb;

    // Geometry of the default 640x480 card, derived the same way the card is
    // specified: fractions of the line width and of the frame height.
    localparam int LINE_PIXELS = 640;
    localparam int FRAME_LINES = 480;
    localparam int BAR_W       = LINE_PIXELS / cbtp_pkg::BAR_COUNT;
    localparam int TOP_END     = FRAME_LINES * cbtp_pkg::TOP_NUM / cbtp_pkg::ROW_DEN;
    localparam int MID_END     = FRAME_LINES * cbtp_pkg::MID_NUM / cbtp_pkg::ROW_DEN;
    localparam int SYNC_LO     = FRAME_LINES * cbtp_pkg::SYNC_LO_NUM / cbtp_pkg::ROW_DEN;
    localparam int SYNC_HI     = FRAME_LINES * cbtp_pkg::SYNC_HI_NUM / cbtp_pkg::ROW_DEN;
    localparam int SPLIT       = LINE_PIXELS * 3 / 4;
    localparam int SEG_W       = (LINE_PIXELS / 4) / 3;
    localparam int SYNC_SPAN   = LINE_PIXELS - cbtp_pkg::SYNC_BLOCK;
    // First threshold column that turns white.
    localparam int THRESH_COL  = ((cbtp_pkg::THRESH_LEVEL + 1) * SPLIT
                                  + cbtp_pkg::THRESH_SCALE - 1) / cbtp_pkg::THRESH_SCALE;

    localparam int LATENCY     = cbtp_pkg::NUM_DIGIT + 1;
    localparam int MAX_BURST   = 15;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [cbtp_pkg::COL_W-1:0]   col;
        logic [cbtp_pkg::ROW_W-1:0]   row;
        logic [cbtp_pkg::FRAME_W-1:0] frame;
        logic [cbtp_pkg::CODE_W-1:0]  code;
    } pixel_want_t;

    // Holds the colour code registers as the bench last wrote them and the
    // palette indexes still owed by the block, oldest first.
    class pixel_scoreboard;
        logic [cbtp_pkg::CODE_W-1:0] code_of [cbtp_pkg::NUM_CODES];
        pixel_want_t                 want_q [$];
        int                          errors;

        function new();
            // each code resets to its own register index
            for (int i = 0; i < cbtp_pkg::NUM_CODES; i++)
                code_of[i] = cbtp_pkg::CODE_W'(i);
            errors = 0;
        endfunction

        function void set_code(cbtp_pkg::colour_t which,
                               logic [cbtp_pkg::CODE_W-1:0] value);
            code_of[which] = value;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function cbtp_pkg::colour_t colour_at(logic [cbtp_pkg::COL_W-1:0] col,
                                              logic [cbtp_pkg::ROW_W-1:0] row,
                                              logic [cbtp_pkg::FRAME_W-1:0] frame);
            int unsigned       x;
            int unsigned       y;
            int unsigned       bar;
            int unsigned       pos;
            cbtp_pkg::colour_t c;
            x   = col;
            y   = row;
            bar = x / BAR_W;
            if (bar > cbtp_pkg::LAST_BAR)
                bar = cbtp_pkg::LAST_BAR;
            if (y < TOP_END) begin
                case (bar)
                    0:       c = cbtp_pkg::CLR_WHITE;
                    1:       c = cbtp_pkg::CLR_YELLOW;
                    2:       c = cbtp_pkg::CLR_CYAN;
                    3:       c = cbtp_pkg::CLR_GREEN;
                    4:       c = cbtp_pkg::CLR_MAGENTA;
                    5:       c = cbtp_pkg::CLR_RED;
                    default: c = cbtp_pkg::CLR_BLUE;
                endcase
            end
            else if (y < MID_END) begin
                case (bar)
                    0:       c = cbtp_pkg::CLR_BLUE;
                    2:       c = cbtp_pkg::CLR_MAGENTA;
                    4:       c = cbtp_pkg::CLR_CYAN;
                    6:       c = cbtp_pkg::CLR_WHITE;
                    default: c = cbtp_pkg::CLR_BLACK;
                endcase
            end
            else begin
                if (x < SPLIT)
                    c = (x * cbtp_pkg::THRESH_SCALE / SPLIT > cbtp_pkg::THRESH_LEVEL) ?
                        cbtp_pkg::CLR_WHITE : cbtp_pkg::CLR_BLACK;
                else begin
                    case ((x - SPLIT) / SEG_W)
                        0:       c = cbtp_pkg::CLR_BLACK;
                        1:       c = cbtp_pkg::CLR_BLUE;
                        default: c = cbtp_pkg::CLR_WHITE;
                    endcase
                end
                // moving sync block, one column per frame
                if (y >= SYNC_LO && y < SYNC_HI) begin
                    pos = frame % SYNC_SPAN;
                    if (x >= pos && x < pos + cbtp_pkg::SYNC_BLOCK)
                        c = cbtp_pkg::CLR_WHITE;
                end
            end
            return c;
        endfunction

        function void note_coord(logic [cbtp_pkg::COL_W-1:0] col,
                                 logic [cbtp_pkg::ROW_W-1:0] row,
                                 logic [cbtp_pkg::FRAME_W-1:0] frame);
            pixel_want_t w;
            w.col   = col;
            w.row   = row;
            w.frame = frame;
            w.code  = code_of[colour_at(col, row, frame)];
            want_q.push_back(w);
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        task check_pixel(logic [cbtp_pkg::CODE_W-1:0] got);
            pixel_want_t w;
            if (want_q.size() == 0)
                report($sformatf("pixel beat %0d with nothing outstanding", got));
            else begin
                w = want_q.pop_front();
                if (got !== w.code)
                    report($sformatf("col %0d row %0d frame %0d: pixel_color %0d, want %0d",
                                     w.col, w.row, w.frame, got, w.code));
            end
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           coord_valid;
    logic                           coord_stall;
    logic [cbtp_pkg::COL_W-1:0]     column;
    logic [cbtp_pkg::ROW_W-1:0]     row;
    logic [cbtp_pkg::FRAME_W-1:0]   frame_number;
    logic                           pixel_valid;
    logic                           pixel_stall;
    logic [cbtp_pkg::CODE_W-1:0]    pixel_color;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [cbtp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cbtp_pkg::CODE_W-1:0]    cfg_data;

    pixel_scoreboard sb = new();

    // Idle odds: 0 means no idling on that side, otherwise a burst starts
    // with probability 1/(odds+1) per opportunity.
    int unsigned send_idle_odds;
    int unsigned recv_idle_odds;
    int unsigned recv_burst_left;
    int unsigned cycles;
    logic        holding;
    event        hold_off;
    logic [cbtp_pkg::CODE_W-1:0] code_plan [cbtp_pkg::NUM_CODES];

    colour_bar_test_pattern_pixel #(
        .LINE_PIXELS (LINE_PIXELS),
        .FRAME_LINES (FRAME_LINES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .coord_valid  (coord_valid),
        .coord_stall  (coord_stall),
        .column       (column),
        .row          (row),
        .frame_number (frame_number),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_color  (pixel_color),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: end the run as failed if it never drains.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering beats
    // until the pipeline fills and coord_stall rises.
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_off);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    // Pixel receiver: check every accepted beat, then pick next cycle's stall.
    // Stall values are updated nonblocking, so the value read here is the one
    // the block saw at this edge.
    initial
    begin
        pixel_stall     = 1'b0;
        recv_burst_left = 0;
        forever
        begin
            @(posedge clk);
            if (pixel_valid && !pixel_stall)
                sb.check_pixel(pixel_color);
            if (holding)
                pixel_stall <= 1'b1;
            else if (recv_burst_left > 0)
            begin
                recv_burst_left--;
                pixel_stall <= 1'b1;
            end
            else if (recv_idle_odds != 0 && $urandom_range(0, recv_idle_odds) == 0)
            begin
                recv_burst_left = $urandom_range(1, MAX_BURST) - 1;
                pixel_stall <= 1'b1;
            end
            else
                pixel_stall <= 1'b0;
        end
    end

    // Offer one coordinate beat, maybe after a random idle burst, and hold it
    // until the block takes it. Leave valid high so back-to-back beats flow.
    task send_coord(input logic [cbtp_pkg::COL_W-1:0] c,
                    input logic [cbtp_pkg::ROW_W-1:0] r,
                    input logic [cbtp_pkg::FRAME_W-1:0] f);
        if (send_idle_odds != 0 && $urandom_range(0, send_idle_odds) == 0)
        begin
            coord_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
        end
        coord_valid  <= 1'b1;
        column       <= c;
        row          <= r;
        frame_number <= f;
        do
            @(posedge clk);
        while (coord_stall);
        sb.note_coord(c, r, f);
    endtask

    // Drop valid and wait until every owed pixel has come back.
    task drain_pixels();
        coord_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write code_plan into the eight code registers; optionally follow with a
    // write to an index past the list, which the block must drop.
    task load_codes(input bit stray);
        for (int i = 0; i < cbtp_pkg::NUM_CODES; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cbtp_pkg::CFG_IDX_W'(i);
            cfg_data  <= code_plan[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_code(cbtp_pkg::colour_t'(i), code_plan[i]);
        end
        if (stray)
        begin
            cfg_index <= cbtp_pkg::CFG_IDX_W'($urandom_range(cbtp_pkg::NUM_CODES,
                                                 (1 << cbtp_pkg::CFG_IDX_W) - 1));
            cfg_data  <= cbtp_pkg::CODE_W'($urandom());
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Hand-picked beats: every bar of both bar bands, the threshold and
    // segment edges, columns and rows past the card, and the sync block at
    // the wrap of the frame counter.
    task run_directed();
        for (int k = 0; k <= cbtp_pkg::LAST_BAR; k++)
            send_coord(cbtp_pkg::COL_W'(k * BAR_W), '0, '0);
        for (int k = 0; k <= cbtp_pkg::LAST_BAR; k++)
            send_coord(cbtp_pkg::COL_W'(k * BAR_W), cbtp_pkg::ROW_W'(TOP_END), '0);
        send_coord('1, cbtp_pkg::ROW_W'(TOP_END - 1), '0);
        send_coord(cbtp_pkg::COL_W'(THRESH_COL - 1), cbtp_pkg::ROW_W'(MID_END), '0);
        send_coord(cbtp_pkg::COL_W'(THRESH_COL), cbtp_pkg::ROW_W'(MID_END), '0);
        send_coord(cbtp_pkg::COL_W'(SPLIT), cbtp_pkg::ROW_W'(FRAME_LINES - 1), '0);
        send_coord(cbtp_pkg::COL_W'(SPLIT + SEG_W), cbtp_pkg::ROW_W'(FRAME_LINES - 1), '0);
        send_coord(cbtp_pkg::COL_W'(SPLIT + 2 * SEG_W),
                   cbtp_pkg::ROW_W'(FRAME_LINES - 1), '0);
        // row past the frame falls to the bottom section, no sync block
        send_coord('0, '1, '0);
        send_coord('0, cbtp_pkg::ROW_W'(SYNC_LO), '0);
        send_coord(cbtp_pkg::COL_W'(cbtp_pkg::SYNC_BLOCK), cbtp_pkg::ROW_W'(SYNC_LO), '0);
        send_coord(cbtp_pkg::COL_W'(LINE_PIXELS - 1), cbtp_pkg::ROW_W'(SYNC_HI - 1),
                   cbtp_pkg::FRAME_W'(SYNC_SPAN - 1));
        send_coord('1, cbtp_pkg::ROW_W'(SYNC_LO), '1);
    endtask

    // Random beats: mostly on the card, a good share aimed at the sync block
    // and at band edges, the rest anywhere in the field ranges.
    task send_random(input int count);
        int                           kind;
        int                           pos;
        logic [cbtp_pkg::COL_W-1:0]   c;
        logic [cbtp_pkg::ROW_W-1:0]   r;
        logic [cbtp_pkg::FRAME_W-1:0] f;
        repeat (count)
        begin
            kind = $urandom_range(0, 9);
            f    = $urandom();
            c    = cbtp_pkg::COL_W'($urandom_range(0, LINE_PIXELS - 1));
            r    = cbtp_pkg::ROW_W'($urandom_range(0, FRAME_LINES - 1));
            case (kind)
                4, 5:
                begin
                    r = cbtp_pkg::ROW_W'($urandom_range(SYNC_LO - 2, SYNC_HI + 1));
                    if (kind == 5)
                    begin
                        case ($urandom_range(0, 3))
                            0:       f = '0;
                            1:       f = cbtp_pkg::FRAME_W'(SYNC_SPAN - 1);
                            2:       f = cbtp_pkg::FRAME_W'(SYNC_SPAN);
                            default: f = '1;
                        endcase
                    end
                    pos = int'(f % SYNC_SPAN)
                          + int'($urandom_range(0, cbtp_pkg::SYNC_BLOCK + 3)) - 2;
                    if (pos < 0)
                        pos = 0;
                    c = cbtp_pkg::COL_W'(pos);
                end
                6:
                begin
                    case ($urandom_range(0, 4))
                        0:       pos = BAR_W * $urandom_range(1, cbtp_pkg::BAR_COUNT);
                        1:       pos = THRESH_COL;
                        2:       pos = SPLIT + SEG_W * $urandom_range(0, 2);
                        3:       pos = LINE_PIXELS;
                        default: pos = (1 << cbtp_pkg::COL_W) - 1;
                    endcase
                    c = cbtp_pkg::COL_W'(pos - $urandom_range(0, 1));
                end
                7:
                begin
                    case ($urandom_range(0, 5))
                        0:       pos = TOP_END;
                        1:       pos = MID_END;
                        2:       pos = SYNC_LO;
                        3:       pos = SYNC_HI;
                        4:       pos = FRAME_LINES;
                        default: pos = (1 << cbtp_pkg::ROW_W) - 1;
                    endcase
                    r = cbtp_pkg::ROW_W'(pos - $urandom_range(0, 1));
                end
                8, 9:
                begin
                    c = cbtp_pkg::COL_W'($urandom());
                    r = cbtp_pkg::ROW_W'($urandom());
                end
                default: ;
            endcase
            send_coord(c, r, f);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        coord_valid    = 1'b0;
        column         = '0;
        row            = '0;
        frame_number   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cycles         = 0;
        send_idle_odds = 6;
        recv_idle_odds = 6;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset codes first, so the reset values are checked too.
        run_directed();
        send_random(200);
        drain_pixels();

        // Random codes, heavier idling, plus a dropped out-of-range write.
        for (int i = 0; i < cbtp_pkg::NUM_CODES; i++)
            code_plan[i] = cbtp_pkg::CODE_W'($urandom());
        load_codes(1'b1);
        send_idle_odds = 3;
        recv_idle_odds = 3;
        send_random(300);
        drain_pixels();

        // Extreme codes, alternating, with no idling on either side.
        for (int i = 0; i < cbtp_pkg::NUM_CODES; i++)
            code_plan[i] = (i % 2 == 0) ? '0 : '1;
        load_codes(1'b0);
        send_idle_odds = 0;
        recv_idle_odds = 0;
        send_random(150);
        drain_pixels();

        // Every code equal: the block must not care.
        for (int i = 0; i < cbtp_pkg::NUM_CODES; i++)
            code_plan[i] = '1;
        load_codes(1'b0);
        send_idle_odds = 5;
        recv_idle_odds = 5;
        send_random(50);
        drain_pixels();

        // Back-pressure: hold the receiver off while beats keep coming.
        for (int i = 0; i < cbtp_pkg::NUM_CODES; i++)
            code_plan[i] = cbtp_pkg::CODE_W'($urandom());
        load_codes(1'b0);
        send_idle_odds = 0;
        recv_idle_odds = 4;
        -> hold_off;
        send_random(250);
        drain_pixels();

        // Last stretch at full rate with no idling anywhere.
        for (int i = 0; i < cbtp_pkg::NUM_CODES; i++)
            code_plan[i] = cbtp_pkg::CODE_W'((1 << cbtp_pkg::CODE_W) - 1 - i);
        load_codes(1'b0);
        send_idle_odds = 0;
        recv_idle_odds = 0;
        send_random(300);
        drain_pixels();

        // Give stray pixel beats time to show up before judging.
        repeat (LATENCY * 4) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
